/* rtl/tcr_pkg.sv */
package tcr_pkg;

    localparam int unsigned VALUE_BITS_DEF = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EUC_DIV,
        ST_EUC_UPD,
        ST_GDIV_B,
        ST_GDIV_C,
        ST_RED_C,
        ST_MUL,
        ST_RED_X,
        ST_XMUL,
        ST_DONE
    } t_state;

endpackage

/* rtl/tcr_divider.sv */
module tcr_divider import tcr_pkg::*; #(
    parameter int unsigned W = 2 * VALUE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("divider done held");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |=> r_busy || o_done) else $error("divider lost");

endmodule

/* rtl/two_coin_representability.sv */
// Two-coin representability test.
// Input channel (i_valid/o_ready) takes coin_a, coin_b and target; each
// word yields one output word (o_valid/i_ready) carrying o_representable,
// which is 1 when target = x*coin_a + y*coin_b for some x, y >= 0.
// The block works on one word at a time and drops o_ready while busy.
// All divisions go through one shared restoring divider that retires one
// quotient bit per cycle. The time per word grows with the Euclid step
// count k (at most about 1.44*VALUE_BITS+2). A zero-target or
// double-zero-coin word goes from the check straight to the result, and a
// word with one zero coin needs a single division.
// A result waits in the output register while i_ready is low; the next
// input word is taken meanwhile, and its result holds the block until the
// waiting one is delivered.
// Reset (synchronous, active low) returns to idle and drops o_valid.
module two_coin_representability import tcr_pkg::*; #(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_coin_a,
    input  logic [15:0] i_coin_b,
    input  logic [15:0] i_target,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_representable
);

    localparam int unsigned VB = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int unsigned DW = 2 * VB;
    localparam int unsigned SW = VB + 2;

    t_state r_state, n_state;

    logic [VB-1:0]        r_a, r_b, r_c;
    logic [VB-1:0]        r_r1, r_g, r_br, r_cg, r_q;
    logic signed [SW-1:0] r_s0, r_s1;
    logic [DW-1:0]        r_prod;
    logic                 r_res;
    logic                 r_out;

    logic          w_start;
    logic [DW-1:0] w_num, w_den;
    logic          w_done;
    logic [DW-1:0] w_quo, w_rem;
    logic [VB-1:0] w_inv;
    logic          w_accept;
    logic          w_out_free;

    tcr_divider #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == ST_IDLE);
    assign w_out_free = !o_valid || i_ready;

    always_comb begin
        if (r_s0 < 0) begin
            w_inv = VB'(r_s0 + SW'(signed'({1'b0, r_br})));
        end else begin
            w_inv = VB'(r_s0);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_accept) n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_c == '0 || (r_a == '0 && r_b == '0)) begin
                    n_state = ST_DONE;
                end else if (r_a == '0 || r_b == '0) begin
                    n_state = ST_GDIV_C;
                end else begin
                    n_state = ST_EUC_DIV;
                end
            end
            ST_EUC_DIV: if (w_done) n_state = ST_EUC_UPD;
            ST_EUC_UPD: n_state = (w_rem == '0) ? ST_GDIV_C : ST_EUC_DIV;
            ST_GDIV_C: begin
                if (w_done) begin
                    if (w_rem != '0 || r_a == '0 || r_b == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_GDIV_B;
                    end
                end
            end
            ST_GDIV_B:  if (w_done) n_state = ST_RED_C;
            ST_RED_C:   if (w_done) n_state = ST_MUL;
            ST_MUL:     n_state = ST_RED_X;
            ST_RED_X:   if (w_done) n_state = ST_XMUL;
            ST_XMUL:    n_state = ST_DONE;
            ST_DONE:    if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_start = 1'b0;
        w_num   = '0;
        w_den   = '1;
        unique case (r_state)
            ST_CHECK: begin
                w_start = 1'b1;
                if (r_a == '0 || r_b == '0) begin
                    w_num = DW'(r_c);
                    w_den = DW'(r_a | r_b);
                end else begin
                    w_num = DW'(r_a);
                    w_den = DW'(r_b);
                end
            end
            ST_EUC_UPD: begin
                w_start = 1'b1;
                if (w_rem == '0) begin
                    w_num = DW'(r_c);
                    w_den = DW'(r_r1);
                end else begin
                    w_num = DW'(r_r1);
                    w_den = w_rem;
                end
            end
            ST_GDIV_C: begin
                w_start = w_done && (w_rem == '0) && (r_a != '0) && (r_b != '0);
                w_num   = DW'(r_b);
                w_den   = DW'(r_g);
            end
            ST_GDIV_B: begin
                w_start = w_done;
                w_num   = DW'(r_cg);
                w_den   = DW'(w_quo[VB-1:0]);
            end
            ST_MUL: begin
                w_start = 1'b1;
                w_num   = r_prod;
                w_den   = DW'(r_br);
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_a   <= i_coin_a[VB-1:0];
                    r_b   <= i_coin_b[VB-1:0];
                    r_c   <= i_target[VB-1:0];
                    r_res <= 1'b1;
                end
            end
            ST_CHECK: begin
                r_r1 <= r_b;
                r_s0 <= SW'(1);
                r_s1 <= '0;
                r_g  <= r_a | r_b;
                if (r_c != '0) r_res <= 1'b0;
            end
            ST_EUC_DIV: if (w_done) r_q <= w_quo[VB-1:0];
            ST_EUC_UPD: begin
                r_r1 <= w_rem[VB-1:0];
                r_s0 <= r_s1;
                r_s1 <= SW'(r_s0 - SW'(signed'({1'b0, r_q})) * r_s1);
                if (w_rem == '0) r_g <= r_r1;
            end
            ST_GDIV_C: begin
                if (w_done) begin
                    r_cg  <= w_quo[VB-1:0];
                    r_res <= (w_rem == '0) && (r_a == '0 || r_b == '0);
                end
            end
            ST_GDIV_B: if (w_done) r_br <= w_quo[VB-1:0];
            ST_RED_C:  if (w_done) r_prod <= DW'(w_rem[VB-1:0]) * DW'(w_inv);
            ST_RED_X:  if (w_done) r_prod <= DW'(w_rem[VB-1:0]) * DW'(r_a);
            ST_XMUL:   r_res <= (r_prod <= DW'(r_c));
            ST_DONE:   if (w_out_free) r_out <= r_res;
            default: begin
            end
        endcase
    end

    assign o_representable = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_valid) else $error("result not shown");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_representable))
        else $error("result changed under stall");
    a_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && (r_c == '0) |-> r_res)
        else $error("zero target rejected");

endmodule

/* tb/two_coin_representability_test.sv */
module two_coin_representability_test import tcr_pkg::*;;

    localparam int unsigned VBITS       = VALUE_BITS_DEF;
    localparam int          CYCLE_LIMIT = 8_000_000;
    localparam int          N_RANDOM    = 1300;
    localparam int          N_DIRECTED  = 22;
    localparam logic [1:0]  ANS_NO      = 2'd0;
    localparam logic [1:0]  ANS_YES     = 2'd1;
    localparam logic [1:0]  ANS_PREDICT = 2'd2;

    typedef struct packed {
        logic [15:0] coin_a;
        logic [15:0] coin_b;
        logic [15:0] target;
        logic [1:0]  answer;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_coin_a;
    logic [15:0] i_coin_b;
    logic [15:0] i_target;
    logic        o_valid;
    logic        i_ready;
    logic        o_representable;

    logic        answers_q[$];
    int          mismatches;
    int          words_in;
    int          words_out;
    int          yes_count;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;
    bit          stim_done;
    t_row        rows[N_DIRECTED];

    two_coin_representability u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_coin_a        (i_coin_a),
        .i_coin_b        (i_coin_b),
        .i_target        (i_target),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_representable (o_representable)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned gcd_of(longint unsigned p, longint unsigned q);
        longint unsigned t;
        while (q != 0) begin
            t = p % q;
            p = q;
            q = t;
        end
        return p;
    endfunction

    function automatic bit coins_reach(logic [15:0] coin_a, logic [15:0] coin_b,
                                       logic [15:0] target);
        longint unsigned a, b, c, g, ar, br, x;
        longint          r0, r1, s0, s1, q, tmp;
        a = coin_a & ((64'd1 << VBITS) - 1);
        b = coin_b & ((64'd1 << VBITS) - 1);
        c = target & ((64'd1 << VBITS) - 1);
        if (c == 0) return 1'b1;
        if (a == 0 && b == 0) return 1'b0;
        if (a == 0) return (c % b) == 0;
        if (b == 0) return (c % a) == 0;
        g = gcd_of(a, b);
        if (c % g != 0) return 1'b0;
        ar = a / g;
        br = b / g;
        r0 = longint'(ar % br);
        r1 = longint'(br);
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = s0 - q * s1;
            s0  = s1;
            s1  = tmp;
        end
        s0 = s0 % longint'(br);
        if (s0 < 0) s0 += longint'(br);
        x = (longint'(s0) * ((c / g) % br)) % br;
        return x * a <= c;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // send one word and hold it until accepted
    task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [1:0] ans);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (ans == ANS_PREDICT) answers_q.push_back(coins_reach(a, b, c));
        else answers_q.push_back(ans == ANS_YES);
        i_valid  <= 1'b1;
        i_coin_a <= a;
        i_coin_b <= b;
        i_target <= c;
        do @(posedge i_clk); while (!o_ready);
        words_in++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (answers_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_word;
        logic [15:0] a, b, c, g;
        int kind;
        kind = $urandom_range(99);
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        if (kind < 30) begin
            a = 16'($urandom_range(1, 60));
            b = 16'($urandom_range(1, 60));
            c = 16'($urandom_range(0, 3000));
        end else if (kind < 50) begin
            g = 16'($urandom_range(1, 40));
            a = 16'(g * $urandom_range(1, 200));
            b = 16'(g * $urandom_range(1, 200));
            c = 16'(g * $urandom_range(0, 1600));
        end else if (kind < 55) begin
            a = 16'd0;
        end else if (kind < 60) begin
            b = 16'd0;
        end else if (kind < 63) begin
            c = 16'd0;
        end
        send_word(a, b, c, ANS_PREDICT);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                words_out++;
                if (answers_q.size() == 0) begin
                    report_mismatch("unexpected output word");
                end else begin
                    if (o_representable) yes_count++;
                    if (o_representable !== answers_q[0])
                        report_mismatch($sformatf("representable %b, want %b",
                                                  o_representable, answers_q[0]));
                    void'(answers_q.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        rows = '{
            '{16'd0,     16'd0,     16'd0,     ANS_YES},
            '{16'd0,     16'd0,     16'd5,     ANS_NO},
            '{16'd0,     16'd7,     16'd21,    ANS_YES},
            '{16'd0,     16'd7,     16'd22,    ANS_NO},
            '{16'd9,     16'd0,     16'd81,    ANS_YES},
            '{16'd9,     16'd0,     16'd80,    ANS_NO},
            '{16'hFFFF,  16'hFFFF,  16'd0,     ANS_YES},
            '{16'hFFFF,  16'hFFFF,  16'hFFFF,  ANS_YES},
            '{16'hFFFF,  16'hFFFE,  16'hFFFD,  ANS_NO},
            '{16'd1,     16'd1,     16'hFFFF,  ANS_YES},
            '{16'd1,     16'hFFFF,  16'hAAAA,  ANS_YES},
            '{16'd3,     16'd5,     16'd7,     ANS_NO},
            '{16'd3,     16'd5,     16'd8,     ANS_YES},
            '{16'd4,     16'd6,     16'd9,     ANS_NO},
            '{16'd4,     16'd6,     16'd10,    ANS_YES},
            '{16'hFFFE,  16'hFFFF,  16'hFFFE,  ANS_YES},
            '{16'h8000,  16'h7FFF,  16'h5555,  ANS_PREDICT},
            '{16'hB1C3,  16'h4E3D,  16'hFFFF,  ANS_PREDICT},
            '{16'd233,   16'd377,   16'd60000, ANS_PREDICT},
            '{16'd987,   16'd610,   16'd1,     ANS_PREDICT},
            '{16'hFFF1,  16'd2,     16'hFFFF,  ANS_PREDICT},
            '{16'd12,    16'd18,    16'hFFFA,  ANS_PREDICT}
        };
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_coin_a       = '0;
        i_coin_b       = '0;
        i_target       = '0;
        mismatches     = 0;
        words_in       = 0;
        words_out      = 0;
        yes_count      = 0;
        cycles         = 0;
        hold_off       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stim_done      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].coin_a, rows[i].coin_b, rows[i].target,
                                    rows[i].answer);
        drain();

        // hold the output long while words keep coming
        hold_off = 6000;
        for (int i = 0; i < 8; i++) random_word();
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin send_idle_pct = 21; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < N_RANDOM / 5; i++) random_word();
        end
        drain();
        repeat (3000) @(posedge i_clk);

        $display("%0d words sent, %0d answers checked (%0d representable)",
                 words_in, words_out, yes_count);
        $display("zero coins, zero targets, full-range and gcd-structured words, long stall");
        if (mismatches == 0 && answers_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d answers missing", mismatches, answers_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/tcr_pkg.sv
rtl/tcr_divider.sv
rtl/two_coin_representability.sv
tb/two_coin_representability_test.sv
